// ----- hdl/xnee_pkg.sv -----
// ----------------------------------------------------------------------------
// xnee_pkg
// Shared types, constants and character class functions of the name encoder.
// ----------------------------------------------------------------------------
package xnee_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned HOLD_DEPTH  = 6;                 // look-ahead bytes
    localparam int unsigned WIN_DEPTH   = HOLD_DEPTH + 1;    // window incl. new byte
    localparam int unsigned CNT_W       = $clog2(WIN_DEPTH + 1);
    localparam int unsigned ESC_LEN     = 7;                 // "_x00HH_"
    localparam int unsigned ESC_IDX_W   = $clog2(ESC_LEN);
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [MODE_W-1:0] MODE_NAME = 2'd0;

    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_DASH       = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_X          = 8'h78;
    localparam logic [BYTE_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0] HIGH_BYTE_MIN = 8'd128;

    // Escape sequence positions
    localparam logic [ESC_IDX_W-1:0] ESC_OPEN  = 3'd0;
    localparam logic [ESC_IDX_W-1:0] ESC_X     = 3'd1;
    localparam logic [ESC_IDX_W-1:0] ESC_PAD0  = 3'd2;
    localparam logic [ESC_IDX_W-1:0] ESC_PAD1  = 3'd3;
    localparam logic [ESC_IDX_W-1:0] ESC_HI    = 3'd4;
    localparam logic [ESC_IDX_W-1:0] ESC_LO    = 3'd5;
    localparam logic [ESC_IDX_W-1:0] ESC_CLOSE = 3'd6;

    // One classified byte handed from front to back
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              esc;
        logic              last;
    } xnee_entry_t;

    // Queue status
    typedef struct packed {
        logic full;
        logic empty;
    } xnee_qstat_t;

    function automatic logic is_alpha(input logic [BYTE_W-1:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_hex(input logic [BYTE_W-1:0] c);
        return is_digit(c) || (c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic is_valid(input logic [BYTE_W-1:0] c, input logic first);
        logic v;
        if (c >= HIGH_BYTE_MIN)
            v = 1'b1;
        else if (first)
            v = is_alpha(c) || c == CH_UNDERSCORE;
        else
            v = is_alpha(c) || is_digit(c) || c == CH_UNDERSCORE ||
                c == CH_DASH || c == CH_DOT;
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_up(input logic [3:0] v);
        logic [BYTE_W-1:0] r;
        if (v < 4'd10)
            r = CH_ZERO + {4'd0, v};
        else
            r = 8'h41 + {4'd0, v - 4'd10};
        return r;
    endfunction

endpackage

// ----- hdl/xnee_front.sv -----
// ----------------------------------------------------------------------------
// xnee_front
// Look-ahead window: accepts name bytes, classifies the oldest one and
// flushes the window when the name ends.
// ----------------------------------------------------------------------------
module xnee_front
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [xnee_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         end_of_name,
    input  logic [xnee_pkg::MODE_W-1:0]  mode,
    output logic                         q_push,
    output xnee_pkg::xnee_entry_t        q_data,
    input  xnee_pkg::xnee_qstat_t        q_stat
);
    import xnee_pkg::*;

    logic [BYTE_W-1:0] win_reg  [WIN_DEPTH];
    logic [BYTE_W-1:0] win_next [WIN_DEPTH];
    logic [BYTE_W-1:0] cand     [WIN_DEPTH];
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              flush_reg, flush_next;
    logic              first_reg, first_next;
    logic [MODE_W-1:0] mode_reg, mode_next;

    logic accept;
    logic emit_shift;     // window full, oldest byte leaves on a non-final transfer
    logic emit_flush;
    logic look_en;
    logic lookalike;
    logic first_chk;

    assign full       = flush_reg || (cnt_reg == CNT_W'(HOLD_DEPTH) && q_stat.full);
    assign accept     = push && !full;
    assign emit_shift = accept && !end_of_name && cnt_reg == CNT_W'(HOLD_DEPTH);
    assign emit_flush = flush_reg && !q_stat.full;

    always_comb
    begin
        for (int i = 0; i < int'(HOLD_DEPTH); i++)
        begin
            cand[i] = win_reg[i];
        end
        cand[HOLD_DEPTH] = flush_reg ? win_reg[HOLD_DEPTH] : data_byte;
    end

    assign look_en   = !flush_reg || cnt_reg == CNT_W'(WIN_DEPTH);
    assign lookalike = look_en && cand[0] == CH_UNDERSCORE && cand[1] == CH_X &&
                       is_hex(cand[2]) && is_hex(cand[3]) && is_hex(cand[4]) &&
                       is_hex(cand[5]) && cand[6] == CH_UNDERSCORE;
    assign first_chk = first_reg && mode_reg == MODE_NAME;

    assign q_push      = emit_shift || emit_flush;
    assign q_data.data = cand[0];
    assign q_data.esc  = !is_valid(cand[0], first_chk) || lookalike;
    assign q_data.last = flush_reg && cnt_reg == CNT_W'(1);

    always_comb
    begin
        win_next   = win_reg;
        cnt_next   = cnt_reg;
        flush_next = flush_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        if (emit_flush)
        begin
            for (int i = 0; i < int'(WIN_DEPTH) - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            cnt_next   = cnt_reg - CNT_W'(1);
            first_next = 1'b0;
            if (cnt_reg == CNT_W'(1))
            begin
                flush_next = 1'b0;
                first_next = 1'b1;
            end
        end
        else if (accept)
        begin
            if (cnt_reg == '0 && first_reg)
                mode_next = mode;
            if (emit_shift)
            begin
                for (int i = 0; i < int'(HOLD_DEPTH) - 1; i++)
                begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[HOLD_DEPTH-1] = data_byte;
                first_next = 1'b0;
            end
            else
            begin
                for (int i = 0; i < int'(WIN_DEPTH); i++)
                begin
                    if (CNT_W'(i) == cnt_reg)
                        win_next[i] = data_byte;
                end
                cnt_next   = cnt_reg + CNT_W'(1);
                flush_next = end_of_name;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            flush_reg <= 1'b0;
            first_reg <= 1'b1;
            mode_reg  <= MODE_NAME;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            flush_reg <= flush_next;
            first_reg <= first_next;
            mode_reg  <= mode_next;
        end
    end

endmodule

// ----- hdl/xnee_queue.sv -----
// ----------------------------------------------------------------------------
// xnee_queue
// Short FIFO of classified bytes between the front and back parts.
// ----------------------------------------------------------------------------
module xnee_queue
#(
    parameter int unsigned DEPTH = xnee_pkg::QUEUE_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  xnee_pkg::xnee_entry_t push_data,
    input  logic                  pop,
    output xnee_pkg::xnee_entry_t pop_data,
    output xnee_pkg::xnee_qstat_t stat
);
    import xnee_pkg::*;

    localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);

    xnee_entry_t        mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = count_reg == COUNT_W'(DEPTH);
    assign stat.empty = count_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + COUNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hdl/xnee_back.sv -----
// ----------------------------------------------------------------------------
// xnee_back
// Output sequencer: passes a byte through or expands it to _x00HH_.
// ----------------------------------------------------------------------------
module xnee_back
(
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         q_pop,
    input  xnee_pkg::xnee_entry_t        q_data,
    input  xnee_pkg::xnee_qstat_t        q_stat,
    output logic                         empty,
    input  logic                         pop,
    output logic [xnee_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_last
);
    import xnee_pkg::*;

    xnee_entry_t          ent_reg, ent_next;
    logic                 busy_reg, busy_next;
    logic [ESC_IDX_W-1:0] idx_reg, idx_next;
    logic                 at_end;
    logic                 finish;
    logic                 take;

    assign at_end = !ent_reg.esc || idx_reg == ESC_CLOSE;
    assign finish = busy_reg && pop && at_end;
    assign take   = !busy_reg || finish;
    assign q_pop  = take && !q_stat.empty;

    assign empty    = !busy_reg;
    assign out_last = ent_reg.last && at_end;

    always_comb
    begin
        if (!ent_reg.esc)
            out_byte = ent_reg.data;
        else
        begin
            unique case (idx_reg)
                ESC_OPEN:  out_byte = CH_UNDERSCORE;
                ESC_X:     out_byte = CH_X;
                ESC_PAD0:  out_byte = CH_ZERO;
                ESC_PAD1:  out_byte = CH_ZERO;
                ESC_HI:    out_byte = hex_up(ent_reg.data[7:4]);
                ESC_LO:    out_byte = hex_up(ent_reg.data[3:0]);
                ESC_CLOSE: out_byte = CH_UNDERSCORE;
                default:   out_byte = CH_UNDERSCORE;
            endcase
        end
    end

    always_comb
    begin
        ent_next  = ent_reg;
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (take)
        begin
            busy_next = !q_stat.empty;
            ent_next  = q_data;
            idx_next  = ESC_OPEN;
        end
        else if (busy_reg && pop)
            idx_next = idx_reg + ESC_IDX_W'(1);
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= ESC_OPEN;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ----- hdl/xml_name_escape_encoder_core.sv -----
// ----------------------------------------------------------------------------
// xml_name_escape_encoder_core
// Streaming XML name encoder with _xHHHH_ escapes for invalid characters.
// ----------------------------------------------------------------------------
// Bytes of a name enter one per transfer on the push side, end_of_name set on
// the final byte; mode is sampled on the first byte of each name (0 name,
// 1 nmtoken, 2 local name; 2 and 3 act like 1). Every byte that is not a valid
// name character comes out as the seven bytes _x00HH_ (uppercase hex), and an
// underscore that starts an escape look-alike (_xhhhh_) inside the name is
// escaped too. Bytes of 128 and up always pass. The front keeps six bytes of
// look-ahead, so output for a name trails its input by six bytes, and the
// held bytes drain when end_of_name arrives. Input rate: one byte per clock
// while the window fills or slides; once six bytes are held, full is also
// raised for as long as the internal queue is full. The transfer that carries
// end_of_name is followed by full while the window drains one byte per cycle
// into the internal queue, and full lasts longer when that queue backs up.
// Output rate: one result byte per clock while pop is held and bytes are
// waiting, so an escaped byte occupies the pop side for seven result bytes, and
// that result sequencer is what bounds throughput on escape-heavy names.
// A queue of QUEUE_DEPTH classified bytes sits between front and back, and
// out_last marks the final result byte of each name.
// ----------------------------------------------------------------------------
module xml_name_escape_encoder_core
#(
    parameter int unsigned QUEUE_DEPTH = xnee_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // input transfer
    input  logic                         push,
    output logic                         full,
    input  logic [xnee_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         end_of_name,
    input  logic [xnee_pkg::MODE_W-1:0]  mode,
    // result transfer
    output logic                         empty,
    input  logic                         pop,
    output logic [xnee_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_last
);
    import xnee_pkg::*;

    logic        q_push;
    logic        q_pop;
    xnee_entry_t q_in;
    xnee_entry_t q_out;
    xnee_qstat_t q_stat;

    // Front: window and classification
    xnee_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .end_of_name (end_of_name),
        .mode        (mode),
        .q_push      (q_push),
        .q_data      (q_in),
        .q_stat      (q_stat)
    );

    // Decoupling queue
    xnee_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .stat      (q_stat)
    );

    // Back: pass-through or escape expansion
    xnee_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_pop    (q_pop),
        .q_data   (q_out),
        .q_stat   (q_stat),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .out_last (out_last)
    );

endmodule

// ----- hdl/xnee_checker.sv -----
// ----------------------------------------------------------------------------
// xnee_checker
// Port-level assertions for the name encoder, bound to the top level.
// ----------------------------------------------------------------------------
module xnee_checker
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         push,
    input logic                         full,
    input logic                         end_of_name,
    input logic                         empty,
    input logic                         pop,
    input logic [xnee_pkg::BYTE_W-1:0]  out_byte,
    input logic                         out_last
);
    import xnee_pkg::*;

    // Nothing to show while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result side not empty during reset");

    // Input side open during reset
    a_reset_not_full: assert property (@(posedge clk) !rst_n |-> !full)
        else $error("input side full during reset");

    // End of name always starts a drain, which closes the input side
    a_end_drains: assert property (@(posedge clk) disable iff (!rst_n)
        push && !full && end_of_name |=> full)
        else $error("no drain after end of name");

    // Waiting result holds until taken
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last))
        else $error("result changed before transfer");

endmodule

bind xml_name_escape_encoder_core xnee_checker u_xnee_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .end_of_name (end_of_name),
    .empty       (empty),
    .pop         (pop),
    .out_byte    (out_byte),
    .out_last    (out_last)
);
